>>> src/cbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cassette block framer.
// Used by every module of the block; depends on nothing.
package cbf_pkg;

   typedef enum logic [1:0] {
      CMD_RAW   = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] START_BYTE = 8'h3c;

   localparam int CFG_WIDTH   = 7;
   localparam int BYTE_WIDTH  = 8;
   localparam int FRONT_SLOTS = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic REG_ZERO_CYCLE = 1'b0;
   localparam logic REG_ONE_CYCLE  = 1'b1;

   localparam logic [CFG_WIDTH-1:0] ZERO_CYCLE_RESET = 7'd10;
   localparam logic [CFG_WIDTH-1:0] ONE_CYCLE_RESET  = 7'd5;

   // One byte on its way from the framer to the serialiser.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] byte_val;
      logic                  final_byte;
   } entry_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] checksum;
      logic                  busy;
   } front_status_type;

endpackage

>>> src/cassette_block_framer_fsk_bits.sv
`timescale 1ns / 1ps
// Cassette block framer with FSK bit output: top level, configuration registers and checks.
// Depends on cbf_pkg, cbf_front, cbf_fifo and cbf_back.

// Each request turns into bytes (raw and data bytes: one; block open: four; block close: two)
// and each byte leaves LSB first as eight responses, one bit per cycle while rsp_ready is high.
// The pace is set by the serialiser, which hands out one bit per cycle; the front end takes
// the next request as soon as the last byte of the current one is queued, and bytes flow
// from request to request without a gap. rsp_last marks the final bit of each request. The
// tone cycle lengths come from two registers (index 0 for a zero bit, index 1 for a one bit),
// sampled as each bit is produced; write them only while idle.
module cassette_block_framer_fsk_bits #(
   parameter int QUEUE_DEPTH = cbf_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_cmd,
   input  logic [7:0]                     req_data_byte,
   input  logic [7:0]                     req_type_code,
   input  logic [7:0]                     req_block_length,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_bit_value,
   output logic [cbf_pkg::CFG_WIDTH-1:0]  rsp_cycle_samples,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [cbf_pkg::CFG_WIDTH-1:0]  csr_wdata
);

   logic [cbf_pkg::CFG_WIDTH-1:0] zero_cycle_ff, zero_cycle_in;
   logic [cbf_pkg::CFG_WIDTH-1:0] one_cycle_ff, one_cycle_in;

   logic                      push_valid, push_ready;
   cbf_pkg::entry_type        push_entry;
   logic                      pop_valid, pop_ready;
   cbf_pkg::entry_type        pop_entry;
   cbf_pkg::front_status_type front_status;

   always_comb begin
      zero_cycle_in = zero_cycle_ff;
      one_cycle_in  = one_cycle_ff;
      if (csr_we) begin
         case (csr_index)
            cbf_pkg::REG_ZERO_CYCLE: zero_cycle_in = csr_wdata;
            cbf_pkg::REG_ONE_CYCLE:  one_cycle_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_cycle_ff <= cbf_pkg::ZERO_CYCLE_RESET;
         one_cycle_ff  <= cbf_pkg::ONE_CYCLE_RESET;
      end else begin
         zero_cycle_ff <= zero_cycle_in;
         one_cycle_ff  <= one_cycle_in;
      end
   end

   cbf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_type_code    (req_type_code),
      .req_block_length (req_block_length),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry),
      .status           (front_status)
   );

   cbf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   cbf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .zero_cycle        (zero_cycle_ff),
      .one_cycle         (one_cycle_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_cycle_samples (rsp_cycle_samples),
      .rsp_last          (rsp_last)
   );

   // The tone length shown must match the bit it accompanies.
   a_tone_matches_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cycle_samples == (rsp_bit_value ? one_cycle_ff : zero_cycle_ff)))
      else $error("cycle_samples does not match bit_value");

   a_open_seeds_checksum: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == cbf_pkg::CMD_OPEN)) |=>
      (front_status.checksum == 8'($past(req_type_code) + $past(req_block_length))))
      else $error("block open did not seed the checksum");

   a_data_adds_checksum: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == cbf_pkg::CMD_DATA)) |=>
      (front_status.checksum == 8'($past(front_status.checksum) + $past(req_data_byte))))
      else $error("data byte was not added to the checksum");

   // A request is only taken when the front end has nothing left to queue after this cycle.
   a_front_drains: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == cbf_pkg::CMD_RAW || req_cmd == cbf_pkg::CMD_DATA))
      |=> front_status.busy)
      else $error("front end lost a request");

endmodule

>>> src/cbf_front.sv
`timescale 1ns / 1ps
// Request front end: decodes a command, builds its byte sequence and keeps the checksum.
// Depends on cbf_pkg.
module cbf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic [7:0]                   req_data_byte,
   input  logic [7:0]                   req_type_code,
   input  logic [7:0]                   req_block_length,
   output logic                         push_valid,
   input  logic                         push_ready,
   output cbf_pkg::entry_type           push_entry,
   output cbf_pkg::front_status_type    status
);

   localparam int CNT_W = $clog2(cbf_pkg::FRONT_SLOTS + 1);

   logic [cbf_pkg::BYTE_WIDTH-1:0] bytes_ff [cbf_pkg::FRONT_SLOTS];
   logic [cbf_pkg::BYTE_WIDTH-1:0] bytes_in [cbf_pkg::FRONT_SLOTS];
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [cbf_pkg::BYTE_WIDTH-1:0] csum_ff, csum_in;
   logic                           fire_push;
   logic                           accept;
   cbf_pkg::cmd_type               cmd;

   assign cmd        = cbf_pkg::cmd_type'(req_cmd);
   assign push_valid = (cnt_ff != '0);
   assign fire_push  = push_valid && push_ready;
   assign req_ready  = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && fire_push);
   assign accept     = req_valid && req_ready;

   assign push_entry.byte_val   = bytes_ff[0];
   assign push_entry.final_byte = (cnt_ff == CNT_W'(1));

   assign status.checksum = csum_ff;
   assign status.busy     = push_valid;

   always_comb begin
      for (int i = 0; i < cbf_pkg::FRONT_SLOTS; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      cnt_in  = cnt_ff;
      csum_in = csum_ff;
      if (fire_push) begin
         for (int i = 0; i < cbf_pkg::FRONT_SLOTS - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (accept) begin
         case (cmd)
            cbf_pkg::CMD_RAW: begin
               bytes_in[0] = req_data_byte;
               cnt_in      = CNT_W'(1);
            end
            cbf_pkg::CMD_OPEN: begin
               bytes_in[0] = cbf_pkg::SYNC_BYTE;
               bytes_in[1] = cbf_pkg::START_BYTE;
               bytes_in[2] = req_type_code;
               bytes_in[3] = req_block_length;
               cnt_in      = CNT_W'(4);
               csum_in     = req_type_code + req_block_length;
            end
            cbf_pkg::CMD_DATA: begin
               bytes_in[0] = req_data_byte;
               cnt_in      = CNT_W'(1);
               csum_in     = csum_ff + req_data_byte;
            end
            default: begin
               // Block close sends the checksum as it stands, then the trailing sync.
               bytes_in[0] = csum_ff;
               bytes_in[1] = cbf_pkg::SYNC_BYTE;
               cnt_in      = CNT_W'(2);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < cbf_pkg::FRONT_SLOTS; i++) begin
         bytes_ff[i] <= bytes_in[i];
      end
      if (reset) begin
         cnt_ff  <= '0;
         csum_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         csum_ff <= csum_in;
      end
   end

endmodule

>>> src/cbf_fifo.sv
`timescale 1ns / 1ps
// Short byte queue between the framer front end and the bit serialiser.
// Depends on cbf_pkg.
module cbf_fifo #(
   parameter int DEPTH = cbf_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cbf_pkg::entry_type  in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output cbf_pkg::entry_type  out_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cbf_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/cbf_back.sv
`timescale 1ns / 1ps
// Bit serialiser: shifts queued bytes out LSB first into a registered result stage.
// Depends on cbf_pkg.
module cbf_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  cbf_pkg::entry_type             pop_entry,
   input  logic [cbf_pkg::CFG_WIDTH-1:0]  zero_cycle,
   input  logic [cbf_pkg::CFG_WIDTH-1:0]  one_cycle,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_bit_value,
   output logic [cbf_pkg::CFG_WIDTH-1:0]  rsp_cycle_samples,
   output logic                           rsp_last
);

   localparam int BITS_W = $clog2(cbf_pkg::BYTE_WIDTH + 1);

   logic [cbf_pkg::BYTE_WIDTH-1:0] sh_ff, sh_in;
   logic [BITS_W-1:0]              bits_ff, bits_in;
   logic                           fin_ff, fin_in;
   logic                           valid_ff, valid_in;
   logic                           bit_ff, bit_in;
   logic [cbf_pkg::CFG_WIDTH-1:0]  samp_ff, samp_in;
   logic                           last_ff, last_in;
   logic                           load;

   assign rsp_valid         = valid_ff;
   assign rsp_bit_value     = bit_ff;
   assign rsp_cycle_samples = samp_ff;
   assign rsp_last          = last_ff;

   assign load = (bits_ff != '0) && (!valid_ff || rsp_ready);
   // The next byte is fetched as the current one hands over its last bit, so bytes run gap-free.
   assign pop_ready = (bits_ff == '0) || ((bits_ff == BITS_W'(1)) && load);

   always_comb begin
      sh_in    = sh_ff;
      bits_in  = bits_ff;
      fin_in   = fin_ff;
      valid_in = valid_ff;
      bit_in   = bit_ff;
      samp_in  = samp_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         bit_in   = sh_ff[0];
         samp_in  = sh_ff[0] ? one_cycle : zero_cycle;
         last_in  = fin_ff && (bits_ff == BITS_W'(1));
         sh_in    = sh_ff >> 1;
         bits_in  = bits_ff - BITS_W'(1);
      end
      if (pop_valid && pop_ready) begin
         sh_in   = pop_entry.byte_val;
         fin_in  = pop_entry.final_byte;
         bits_in = BITS_W'(cbf_pkg::BYTE_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      fin_ff  <= fin_in;
      bit_ff  <= bit_in;
      samp_ff <= samp_in;
      last_ff <= last_in;
      if (reset) begin
         bits_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         valid_ff <= valid_in;
      end
   end

endmodule
